### rtl/core/tcsa_pkg.sv
`timescale 1ns / 1ps

package tcsa_pkg;

  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GEAR_FLOOR   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEAR_JUMP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_LOW     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BATT_HIGH    = 2'd3;

  localparam logic [CFG_W-1:0] GEAR_FLOOR_RST = 8'd20;
  localparam logic [CFG_W-1:0] GEAR_JUMP_RST  = 8'd16;
  localparam logic [CFG_W-1:0] BATT_LOW_RST   = 8'd160;
  localparam logic [CFG_W-1:0] BATT_HIGH_RST  = 8'd225;

  // Output queue: three entries keep one item per cycle, while out_stall is low,
  // with the extra stage between state update and result capture.
  localparam int unsigned OUTQ_DEPTH = 3;
  localparam int unsigned OUTQ_PTR_W = 2;

  typedef struct packed {
    logic                occ;
    logic [SAMPLE_W-1:0] sample;
  } tcsa_cell_t;

  typedef struct packed {
    logic push;
    logic flush;
  } tcsa_chan_ctrl_t;

  typedef struct packed {
    logic                full;
    logic [SAMPLE_W-1:0] average;
  } tcsa_chan_stat_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] gear_average;
    logic [SAMPLE_W-1:0] battery_average;
    logic                battery_alarm;
  } tcsa_result_t;

endpackage

### rtl/core/two_channel_sensor_averager.sv
`timescale 1ns / 1ps

// Two-channel sliding-window averager for 8-bit sensor samples.
// Input channel: in_sample with in_is_battery (1 battery, 0 gear), taken when
// in_valid is high and in_stall is low. Each item produces exactly one
// result on the output channel: both channel averages (0 until a window is
// full) and the battery alarm, taken when out_valid is high and out_stall low.
// Gear samples at or below the floor leave the state alone; a gear sample too
// far from the full-window average restarts the gear window.
// The window state updates when an item is accepted; the result is registered
// into the output queue through pend_r and offered from there.
// Throughput: one item per cycle while in_stall stays low; the window average
// is combinational, and the jump check reads the average straight from the
// running total.
// A three-entry output queue absorbs items in flight; in_stall rises only
// when queue plus in-flight item reach three, so a stalled receiver holds
// the output steady and pushes back after at most three further items.
// Reset (rst_n low at a clock edge) empties both windows and the queue and
// loads the default floor, jump limit and battery bounds.
// cfg_we writes cfg_wdata into register cfg_index; write only while idle.

module two_channel_sensor_averager #(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tcsa_pkg::SAMPLE_W-1:0]      in_sample,
  input  logic                               in_is_battery,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tcsa_pkg::SAMPLE_W-1:0]      out_gear_average,
  output logic [tcsa_pkg::SAMPLE_W-1:0]      out_battery_average,
  output logic                               out_battery_alarm,
  input  logic                               cfg_we,
  input  logic [tcsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tcsa_pkg::CFG_W-1:0]         cfg_wdata
);
  import tcsa_pkg::*;

  logic [CFG_W-1:0] gear_floor_r;
  logic [CFG_W-1:0] gear_jump_r;
  logic [CFG_W-1:0] batt_low_r;
  logic [CFG_W-1:0] batt_high_r;

  logic in_acc;
  logic out_acc;

  tcsa_chan_ctrl_t gear_ctrl;
  tcsa_chan_ctrl_t batt_ctrl;
  tcsa_chan_stat_t gear_stat;
  tcsa_chan_stat_t batt_stat;

  logic [SAMPLE_W-1:0] gear_dev;

  logic                  pend_r;
  logic [OUTQ_PTR_W-1:0] occ_r;
  logic [OUTQ_PTR_W-1:0] occ_nxt;
  logic [OUTQ_PTR_W-1:0] cnt_r;
  logic [OUTQ_PTR_W-1:0] cnt_nxt;
  logic [OUTQ_PTR_W-1:0] wr_ptr_r;
  logic [OUTQ_PTR_W-1:0] rd_ptr_r;
  tcsa_result_t          outq_r [OUTQ_DEPTH];
  tcsa_result_t          res_new;
  tcsa_result_t          res_head;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gear_floor_r <= GEAR_FLOOR_RST;
      gear_jump_r  <= GEAR_JUMP_RST;
      batt_low_r   <= BATT_LOW_RST;
      batt_high_r  <= BATT_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GEAR_FLOOR: gear_floor_r <= cfg_wdata;
        REG_GEAR_JUMP:  gear_jump_r  <= cfg_wdata;
        REG_BATT_LOW:   batt_low_r   <= cfg_wdata;
        REG_BATT_HIGH:  batt_high_r  <= cfg_wdata;
      endcase
    end
  end

  assign in_stall = (occ_r == OUTQ_PTR_W'(OUTQ_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;

  // gear: drop at or below floor, restart the window on a jump once full
  assign gear_dev = (gear_stat.average > in_sample) ? gear_stat.average - in_sample
                                                    : in_sample - gear_stat.average;

  assign gear_ctrl.push  = in_acc && !in_is_battery && (in_sample > gear_floor_r);
  assign gear_ctrl.flush = gear_ctrl.push && gear_stat.full && (gear_dev > gear_jump_r);
  assign batt_ctrl.push  = in_acc && in_is_battery;
  assign batt_ctrl.flush = 1'b0;

  tcsa_chan #(.WINDOW_SIZE(WINDOW_SIZE)) u_gear (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (gear_ctrl),
    .sample (in_sample),
    .stat   (gear_stat)
  );

  tcsa_chan #(.WINDOW_SIZE(WINDOW_SIZE)) u_batt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (batt_ctrl),
    .sample (in_sample),
    .stat   (batt_stat)
  );

  // in the cycle after the update the averages reflect the item
  assign res_new.gear_average    = gear_stat.average;
  assign res_new.battery_average = batt_stat.average;
  assign res_new.battery_alarm   = (batt_stat.average < batt_low_r) ||
                                   (batt_stat.average > batt_high_r);

  assign occ_nxt = occ_r + OUTQ_PTR_W'(in_acc) - OUTQ_PTR_W'(out_acc);
  assign cnt_nxt = cnt_r + OUTQ_PTR_W'(pend_r) - OUTQ_PTR_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= 1'b0;
      occ_r    <= '0;
      cnt_r    <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      pend_r <= in_acc;
      occ_r  <= occ_nxt;
      cnt_r  <= cnt_nxt;
      if (pend_r) begin
        wr_ptr_r <= (wr_ptr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                              : wr_ptr_r + OUTQ_PTR_W'(1);
      end
      if (out_acc) begin
        rd_ptr_r <= (rd_ptr_r == OUTQ_PTR_W'(OUTQ_DEPTH - 1)) ? '0
                                                              : rd_ptr_r + OUTQ_PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_r) begin
      outq_r[wr_ptr_r] <= res_new;
    end
  end

  assign res_head            = outq_r[rd_ptr_r];
  assign out_valid           = (cnt_r != '0);
  assign out_gear_average    = res_head.gear_average;
  assign out_battery_average = res_head.battery_average;
  assign out_battery_alarm   = res_head.battery_alarm;

  a_occ_balance: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r == (cnt_r + OUTQ_PTR_W'(pend_r)))
    else $error("in-flight count out of step with output queue");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= OUTQ_PTR_W'(OUTQ_DEPTH))
    else $error("output queue overflow");

  a_pend_lands: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |=> out_valid)
    else $error("pending item did not reach the output queue");

endmodule

### rtl/core/tcsa_cell.sv
`timescale 1ns / 1ps

module tcsa_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift,
  input  logic                 flush,
  input  tcsa_pkg::tcsa_cell_t cell_in,
  output tcsa_pkg::tcsa_cell_t cell_out
);
  import tcsa_pkg::*;

  logic                occ_r;
  logic                occ_nxt;
  logic [SAMPLE_W-1:0] sample_r;

  // a flushed cell drops out of the window; its sample is dead data
  assign occ_nxt = cell_in.occ & ~flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else if (shift) begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sample_r <= cell_in.sample;
    end
  end

  assign cell_out.occ    = occ_r;
  assign cell_out.sample = sample_r;

endmodule

### rtl/core/tcsa_chan.sv
`timescale 1ns / 1ps

module tcsa_chan #(
  parameter int unsigned WINDOW_SIZE = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tcsa_pkg::tcsa_chan_ctrl_t           ctrl,
  input  logic [tcsa_pkg::SAMPLE_W-1:0]       sample,
  output tcsa_pkg::tcsa_chan_stat_t           stat
);
  import tcsa_pkg::*;

  localparam int unsigned TOTAL_W = $clog2(255 * WINDOW_SIZE + 1);
  localparam int unsigned SHIFT   = TOTAL_W + $clog2(WINDOW_SIZE);
  localparam int unsigned PROD_W  = TOTAL_W + SHIFT;
  // ceil(2^SHIFT / N): exact floor division for every total below 2^TOTAL_W
  localparam logic [SHIFT-1:0] RECIP =
    SHIFT'(((64'd1 << SHIFT) + 64'(WINDOW_SIZE) - 64'd1) / 64'(WINDOW_SIZE));

  tcsa_cell_t link [WINDOW_SIZE+1];

  logic [TOTAL_W-1:0]  total_r;
  logic [TOTAL_W-1:0]  total_nxt;
  logic [TOTAL_W-1:0]  leaving;
  logic [PROD_W-1:0]   prod;
  logic                full;

  assign link[0].occ    = 1'b1;
  assign link[0].sample = sample;

  genvar i;
  generate
    for (i = 0; i < WINDOW_SIZE; i++) begin : g_cell
      tcsa_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (ctrl.push),
        .flush    ((i == 0) ? 1'b0 : ctrl.flush),
        .cell_in  (link[i]),
        .cell_out (link[i+1])
      );
    end
  endgenerate

  // the last cell holds the oldest sample once the window is full
  assign full    = link[WINDOW_SIZE].occ;
  assign leaving = full ? TOTAL_W'(link[WINDOW_SIZE].sample) : '0;

  always_comb begin
    total_nxt = total_r;
    if (ctrl.push) begin
      if (ctrl.flush) begin
        total_nxt = TOTAL_W'(sample);
      end else begin
        total_nxt = total_r - leaving + TOTAL_W'(sample);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

  assign prod         = PROD_W'(total_r) * PROD_W'(RECIP);
  assign stat.full    = full;
  assign stat.average = full ? prod[SHIFT +: SAMPLE_W] : '0;

  a_flush_with_push: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.flush |-> ctrl.push)
    else $error("window flush without a push");

  a_full_head_occ: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> link[1].occ)
    else $error("window full while the newest cell is empty");

  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (total_r <= TOTAL_W'(255 * (WINDOW_SIZE - 1))))
    else $error("running total too large for a filling window");

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
  import tcsa_pkg::*;

  localparam int unsigned WIN         = 8;
  localparam int          GEAR_CH     = 0;
  localparam int          BATT_CH     = 1;
  localparam int          PHASES      = 7;
  localparam int          PHASE_ITEMS = 200;
  localparam int          HOLD_CYCLES = 300;
  localparam int          STUCK_LIMIT = 2000;
  localparam int          DIR_ROWS    = 22;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                is_battery;
    logic                typed;
    tcsa_result_t        want;
  } stim_row_t;

  typedef struct packed {
    logic [CFG_W-1:0] floor_v;
    logic [CFG_W-1:0] jump_v;
    logic [CFG_W-1:0] low_v;
    logic [CFG_W-1:0] high_v;
  } limits_t;

  // Rows at the reset settings: floor 20, jump 16, band 160..225.
  localparam stim_row_t DIRECTED [DIR_ROWS] = '{
    '{8'd0,   1'b0, 1'b1, '{8'd0,   8'd0,   1'b1}},  // below floor, dropped
    '{8'd20,  1'b0, 1'b1, '{8'd0,   8'd0,   1'b1}},  // at floor, dropped
    '{8'd255, 1'b0, 1'b1, '{8'd0,   8'd0,   1'b1}},
    '{8'd255, 1'b1, 1'b1, '{8'd0,   8'd0,   1'b1}},
    '{8'd255, 1'b1, 1'b1, '{8'd0,   8'd0,   1'b1}},
    '{8'd255, 1'b1, 1'b1, '{8'd0,   8'd0,   1'b1}},
    '{8'd255, 1'b1, 1'b1, '{8'd0,   8'd0,   1'b1}},
    '{8'd255, 1'b1, 1'b1, '{8'd0,   8'd0,   1'b1}},
    '{8'd255, 1'b1, 1'b1, '{8'd0,   8'd0,   1'b1}},
    '{8'd255, 1'b1, 1'b1, '{8'd0,   8'd0,   1'b1}},
    '{8'd255, 1'b1, 1'b1, '{8'd0,   8'd255, 1'b1}},  // battery full, above band
    '{8'd255, 1'b0, 1'b1, '{8'd0,   8'd255, 1'b1}},
    '{8'd255, 1'b0, 1'b1, '{8'd0,   8'd255, 1'b1}},
    '{8'd255, 1'b0, 1'b1, '{8'd0,   8'd255, 1'b1}},
    '{8'd255, 1'b0, 1'b1, '{8'd0,   8'd255, 1'b1}},
    '{8'd255, 1'b0, 1'b1, '{8'd0,   8'd255, 1'b1}},
    '{8'd255, 1'b0, 1'b1, '{8'd0,   8'd255, 1'b1}},
    '{8'd255, 1'b0, 1'b1, '{8'd255, 8'd255, 1'b1}},  // gear full
    '{8'd200, 1'b0, 1'b1, '{8'd0,   8'd255, 1'b1}},  // jump restarts gear window
    '{8'd21,  1'b0, 1'b0, '0},
    '{8'd0,   1'b1, 1'b0, '0},
    '{8'd128, 1'b1, 1'b0, '0}
  };

  // Extremes first, then the reset settings and crossed bounds; later phases draw at random.
  localparam limits_t FIXED_LIMITS [4] = '{
    '{8'd0,   8'd0,   8'd0,   8'd255},
    '{8'd255, 8'd255, 8'd255, 8'd0},
    '{8'd20,  8'd16,  8'd160, 8'd225},
    '{8'd100, 8'd4,   8'd200, 8'd100}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [SAMPLE_W-1:0]  in_sample = '0;
  logic                 in_is_battery = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SAMPLE_W-1:0]  out_gear_average;
  logic [SAMPLE_W-1:0]  out_battery_average;
  logic                 out_battery_alarm;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  // Predictor state: one sliding window per channel plus register copies.
  logic [SAMPLE_W-1:0] win_store [2][WIN];
  logic [10:0]         win_sum [2];
  int unsigned         win_pos [2];
  int unsigned         win_fill [2];
  logic [CFG_W-1:0]    gear_floor_r = GEAR_FLOOR_RST;
  logic [CFG_W-1:0]    gear_jump_r  = GEAR_JUMP_RST;
  logic [CFG_W-1:0]    batt_low_r   = BATT_LOW_RST;
  logic [CFG_W-1:0]    batt_high_r  = BATT_HIGH_RST;

  tcsa_result_t pending_results [$];
  int           fault_count = 0;
  bit           hold_req = 1'b0;
  bit           tx_busy = 1'b0;

  two_channel_sensor_averager DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample           (in_sample),
    .in_is_battery       (in_is_battery),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_gear_average    (out_gear_average),
    .out_battery_average (out_battery_average),
    .out_battery_alarm   (out_battery_alarm),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic [SAMPLE_W-1:0] window_mean(int ch);
    if (win_fill[ch] < WIN) return '0;
    return SAMPLE_W'(win_sum[ch] / WIN);
  endfunction

  function automatic void window_clear(int ch);
    for (int i = 0; i < WIN; i++) win_store[ch][i] = '0;
    win_sum[ch]  = '0;
    win_pos[ch]  = 0;
    win_fill[ch] = 0;
  endfunction

  function automatic void window_push(int ch, logic [SAMPLE_W-1:0] v);
    win_sum[ch] = win_sum[ch] - win_store[ch][win_pos[ch]] + v;
    win_store[ch][win_pos[ch]] = v;
    win_pos[ch] = (win_pos[ch] + 1) % WIN;
    if (win_fill[ch] < WIN) win_fill[ch]++;
  endfunction

  function automatic tcsa_result_t averager_step(logic [SAMPLE_W-1:0] s, logic isb);
    tcsa_result_t        r;
    logic [SAMPLE_W-1:0] mean;
    logic [SAMPLE_W-1:0] dev;
    if (isb) begin
      window_push(BATT_CH, s);
    end else if (s > gear_floor_r) begin
      // jump check only once the window is full
      if (win_fill[GEAR_CH] >= WIN) begin
        mean = window_mean(GEAR_CH);
        dev  = (mean > s) ? mean - s : s - mean;
        if (dev > gear_jump_r) window_clear(GEAR_CH);
      end
      window_push(GEAR_CH, s);
    end
    r.gear_average    = window_mean(GEAR_CH);
    r.battery_average = window_mean(BATT_CH);
    r.battery_alarm   = (r.battery_average < batt_low_r) ||
                        (r.battery_average > batt_high_r);
    return r;
  endfunction

  task automatic report_fault(input string msg);
    fault_count++;
    if (fault_count <= 10) $display("%s", msg);
  endtask

  task automatic offer_sample(input logic [SAMPLE_W-1:0] s, input logic isb,
                             input bit typed, input tcsa_result_t typed_res);
    int unsigned  gap;
    tcsa_result_t pred;
    gap = tx_busy ? 0 : $urandom_range(0, 17);
    if ($urandom_range(0, 39) == 0) tx_busy = !tx_busy;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_sample     <= s;
    in_is_battery <= isb;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = averager_step(s, isb);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GEAR_FLOOR: gear_floor_r = val;
      REG_GEAR_JUMP:  gear_jump_r  = val;
      REG_BATT_LOW:   batt_low_r   = val;
      REG_BATT_HIGH:  batt_high_r  = val;
      default: ;
    endcase
  endtask

  // Drop valid and wait for every outstanding result to drain.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [SAMPLE_W-1:0] near(logic [SAMPLE_W-1:0] base, int spread);
    int v;
    v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return SAMPLE_W'(v);
  endfunction

  // Result side: random stalls, one long hold-off on request.
  initial begin
    int unsigned  hold;
    bit           rx_busy;
    tcsa_result_t got;
    tcsa_result_t want;
    rx_busy = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end else begin
        hold = rx_busy ? 0 : $urandom_range(0, 17);
      end
      if ($urandom_range(0, 39) == 0) rx_busy = !rx_busy;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      got.gear_average    = out_gear_average;
      got.battery_average = out_battery_average;
      got.battery_alarm   = out_battery_alarm;
      if (pending_results.size() == 0) begin
        report_fault($sformatf("unexpected result: gear %0d battery %0d alarm %0b",
                               got.gear_average, got.battery_average, got.battery_alarm));
      end else begin
        want = pending_results.pop_front();
        if (got.gear_average !== want.gear_average ||
            got.battery_average !== want.battery_average ||
            got.battery_alarm !== want.battery_alarm)
          report_fault($sformatf(
            "mismatch: expected gear %0d battery %0d alarm %0b, got gear %0d battery %0d alarm %0b",
            want.gear_average, want.battery_average, want.battery_alarm,
            got.gear_average, got.battery_average, got.battery_alarm));
      end
    end
  end

  // Watchdog: end the run if no item moves on either side for too long.
  initial begin
    int stuck;
    stuck = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        stuck = 0;
      else
        stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int                  counted;
    int                  run_len;
    int                  spread;
    logic [SAMPLE_W-1:0] gear_base;
    logic [SAMPLE_W-1:0] batt_base;
    logic [SAMPLE_W-1:0] s;
    logic                isb;
    limits_t             lim;
    window_clear(GEAR_CH);
    window_clear(BATT_CH);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIR_ROWS; r++)
      offer_sample(DIRECTED[r].sample, DIRECTED[r].is_battery,
                   DIRECTED[r].typed, DIRECTED[r].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase < 4) begin
        lim = FIXED_LIMITS[phase];
      end else begin
        lim.floor_v = CFG_W'($urandom_range(0, 80));
        lim.jump_v  = CFG_W'($urandom_range(0, 40));
        lim.low_v   = CFG_W'($urandom_range(0, 255));
        lim.high_v  = CFG_W'($urandom_range(0, 255));
      end
      write_reg(REG_GEAR_FLOOR, lim.floor_v);
      write_reg(REG_GEAR_JUMP,  lim.jump_v);
      write_reg(REG_BATT_LOW,   lim.low_v);
      write_reg(REG_BATT_HIGH,  lim.high_v);
      cfg_we <= 1'b0;
      if (phase == 2) hold_req = 1'b1;

      // Bursts of steady readings let windows fill; a few wild ones break them.
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        gear_base = SAMPLE_W'($urandom_range(0, 255));
        batt_base = SAMPLE_W'($urandom_range(0, 255));
        case ($urandom_range(0, 2))
          0:       spread = 2;
          1:       spread = 8;
          default: spread = 24;
        endcase
        run_len = $urandom_range(8, 40);
        for (int k = 0; k < run_len; k++) begin
          isb = ($urandom_range(0, 9) < 4);
          if ($urandom_range(0, 9) == 0)
            s = SAMPLE_W'($urandom_range(0, 255));
          else
            s = near(isb ? batt_base : gear_base, spread);
          offer_sample(s, isb, 1'b0, '0);
          counted++;
        end
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (fault_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
